// ----- hw/rtl/cputf8_pkg.sv -----
// ----------------------------------------------------------------------------
// cputf8_pkg: shared types and constants of the codepage/UTF-8 transcoder
// Payload structs, item kinds, status codes, register indexes, controller
// commands and datapath status.
// ----------------------------------------------------------------------------
package cputf8_pkg;

   localparam int RevDepth = 512;
   localparam int RevAddrW = $clog2(RevDepth);
   localparam int RevCntW  = $clog2(RevDepth + 1);
   localparam int PointW   = 21;

   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_FWD    = 2'd1;
   localparam logic [1:0] KIND_REV    = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [1:0] ST_MAPPED   = 2'd0;
   localparam logic [1:0] ST_FALLBACK = 2'd1;
   localparam logic [1:0] ST_LOADED   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic CSR_FALLBACK_UNICODE = 1'b0;
   localparam logic CSR_FALLBACK_CODE    = 1'b1;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        code_byte;
      logic [PointW-1:0] unicode_point;
      logic [7:0]        utf8_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
      logic [1:0] status;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // latch the request, read forward table
      logic scan_start;  // restart reverse scan at entry 0
      logic scan_step;   // advance reverse scan by one entry
      logic load_commit; // write tables for a load item
      logic fwd_prep;    // pick point and build UTF-8 bytes
      logic dec_update;  // apply reverse byte to decoder state
      logic rev_result;  // build code result from scan outcome
      logic shift_out;   // advance to next UTF-8 byte
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] kind;
      logic       scan_done;
      logic       dec_complete;
      logic [2:0] nbytes;
   } stat_type;

endpackage

// ----- hw/rtl/cputf8_datapath.sv -----
// ----------------------------------------------------------------------------
// cputf8_datapath: tables, reverse scan, UTF-8 encoder and decoder
// Holds the forward and reverse tables and works under controller commands.
// ----------------------------------------------------------------------------
module cputf8_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic                 csr_index,
   input  logic [20:0]          csr_wdata,
   input  cputf8_pkg::req_type  item,
   input  cputf8_pkg::cmd_type  cmd,
   output cputf8_pkg::stat_type stat,
   output cputf8_pkg::rsp_type  result
);
   import cputf8_pkg::*;

   logic [PointW-1:0] fb_uni_ff;
   logic [7:0]        fb_code_ff;
   req_type           req_ff;

   logic [PointW-1:0] fwd_mem [256];
   logic [255:0]      fwd_valid_ff;
   logic [PointW-1:0] fwd_rd_ff;
   logic              fwd_hit_ff;

   logic [PointW-1:0] rev_pt_mem   [RevDepth];
   logic [7:0]        rev_code_mem [RevDepth];
   logic [RevCntW-1:0] rev_cnt_ff;
   logic [RevCntW-1:0] scan_ff;
   logic [PointW-1:0] rd_pt_ff;
   logic [7:0]        rd_code_ff;
   logic              rd_vld_ff;
   logic              found_ff;
   logic [7:0]        found_code_ff;
   logic [PointW-1:0] key_ff;

   logic [PointW-1:0] partial_ff;
   logic [1:0]        pending_ff;
   logic              complete_ff;

   logic [31:0]       bytes_ff;
   logic [2:0]        nbytes_ff;
   logic [1:0]        st_ff;
   rsp_type           result_ff;

   logic [PointW-1:0] dec_key;
   logic [PointW-1:0] fp;
   logic [RevAddrW-1:0] scan_addr;

   assign scan_addr = scan_ff[RevAddrW-1:0];
   assign fp = fwd_hit_ff ? fwd_rd_ff : fb_uni_ff;

   // next decoder value for a byte that continues an open sequence
   always_comb begin
      dec_key = {{(PointW-8){1'b0}}, req_ff.utf8_byte};
      if (pending_ff != 2'd0) begin
         dec_key = {partial_ff[PointW-7:0], req_ff.utf8_byte[5:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_uni_ff    <= PointW'(63);
         fb_code_ff   <= 8'd63;
         fwd_valid_ff <= '0;
         rev_cnt_ff   <= '0;
         partial_ff   <= '0;
         pending_ff   <= '0;
         complete_ff  <= 1'b0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         scan_ff      <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_FALLBACK_UNICODE: fb_uni_ff  <= csr_wdata;
               CSR_FALLBACK_CODE:    fb_code_ff <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (cmd.capture) begin
            req_ff     <= item;
            fwd_hit_ff <= fwd_valid_ff[item.code_byte];
            fwd_rd_ff  <= fwd_mem[item.code_byte];
         end
         // reverse scan: one entry read per cycle, compared in the cycle after its read
         if (cmd.scan_start) begin
            scan_ff   <= '0;
            found_ff  <= 1'b0;
            rd_vld_ff <= 1'b0;
            key_ff    <= (req_ff.kind == KIND_LOAD) ? req_ff.unicode_point : partial_ff;
         end else if (cmd.scan_step) begin
            rd_vld_ff <= (scan_ff < rev_cnt_ff) && !found_ff;
            if (scan_ff < rev_cnt_ff && !found_ff) begin
               rd_pt_ff   <= rev_pt_mem[scan_addr];
               rd_code_ff <= rev_code_mem[scan_addr];
               scan_ff    <= scan_ff + 1'b1;
            end
            if (rd_vld_ff && rd_pt_ff == key_ff && !found_ff) begin
               found_ff      <= 1'b1;
               found_code_ff <= rd_code_ff;
            end
         end else begin
            rd_vld_ff <= 1'b0;
         end
         if (cmd.load_commit) begin
            if (!fwd_valid_ff[req_ff.code_byte]) begin
               fwd_valid_ff[req_ff.code_byte] <= 1'b1;
               fwd_mem[req_ff.code_byte]      <= req_ff.unicode_point;
            end
            if (!found_ff && rev_cnt_ff < RevCntW'(RevDepth)) begin
               rev_pt_mem[scan_addr]   <= req_ff.unicode_point;
               rev_code_mem[scan_addr] <= req_ff.code_byte;
               rev_cnt_ff <= rev_cnt_ff + 1'b1;
            end
            result_ff <= '{out_byte: 8'd0, last: 1'b1,
                           status: (found_ff || rev_cnt_ff < RevCntW'(RevDepth))
                                   ? ST_LOADED : ST_FULL};
         end
         if (cmd.dec_update) begin
            if (pending_ff != 2'd0) begin
               partial_ff  <= dec_key;
               pending_ff  <= pending_ff - 2'd1;
               complete_ff <= (pending_ff == 2'd1);
            end else if (req_ff.utf8_byte[7:5] == 3'b110) begin
               partial_ff  <= PointW'(req_ff.utf8_byte[4:0]);
               pending_ff  <= 2'd1;
               complete_ff <= 1'b0;
            end else if (req_ff.utf8_byte[7:4] == 4'b1110) begin
               partial_ff  <= PointW'(req_ff.utf8_byte[3:0]);
               pending_ff  <= 2'd2;
               complete_ff <= 1'b0;
            end else if (req_ff.utf8_byte[7:3] == 5'b11110) begin
               partial_ff  <= PointW'(req_ff.utf8_byte[2:0]);
               pending_ff  <= 2'd3;
               complete_ff <= 1'b0;
            end else begin
               // lone byte: the point is the byte value itself
               partial_ff  <= PointW'(req_ff.utf8_byte);
               complete_ff <= 1'b1;
            end
         end
         if (cmd.rev_result) begin
            result_ff <= found_ff ? '{found_code_ff, 1'b1, ST_MAPPED}
                                  : '{fb_code_ff, 1'b1, ST_FALLBACK};
         end
         if (cmd.fwd_prep) begin
            st_ff <= fwd_hit_ff ? ST_MAPPED : ST_FALLBACK;
            if (fp < PointW'('h80)) begin
               nbytes_ff <= 3'd1;
               bytes_ff  <= {1'b0, fp[6:0], 24'd0};
            end else if (fp < PointW'('h800)) begin
               nbytes_ff <= 3'd2;
               bytes_ff  <= {3'b110, fp[10:6], 2'b10, fp[5:0], 16'd0};
            end else if (fp < PointW'('h10000)) begin
               nbytes_ff <= 3'd3;
               bytes_ff  <= {4'b1110, fp[15:12], 2'b10, fp[11:6], 2'b10, fp[5:0], 8'd0};
            end else begin
               nbytes_ff <= 3'd4;
               bytes_ff  <= {5'b11110, fp[20:18], 2'b10, fp[17:12], 2'b10, fp[11:6],
                             2'b10, fp[5:0]};
            end
         end
         if (cmd.shift_out) begin
            result_ff <= '{bytes_ff[31:24], nbytes_ff == 3'd1, st_ff};
            bytes_ff  <= {bytes_ff[23:0], 8'd0};
            nbytes_ff <= nbytes_ff - 3'd1;
         end
      end
   end

   assign stat.kind         = req_ff.kind;
   assign stat.scan_done    = !rd_vld_ff && (found_ff || scan_ff >= rev_cnt_ff);
   assign stat.dec_complete = complete_ff;
   assign stat.nbytes       = nbytes_ff;
   assign result            = result_ff;

endmodule

// ----- hw/rtl/cputf8_ctrl.sv -----
// ----------------------------------------------------------------------------
// cputf8_ctrl: sequencing controller of the transcoder
// Walks each item through its lookup, decode, scan, load and emit steps; owns the handshake.
// ----------------------------------------------------------------------------
module cputf8_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cputf8_pkg::stat_type stat,
   output cputf8_pkg::cmd_type  cmd
);
   import cputf8_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_SCAN, S_LOAD, S_DEC, S_FWD, S_EMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      rsp_free;
   logic      take;

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign take      = req_valid && state_ff == S_IDLE && req_kind != KIND_UNUSED;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.capture = take;
      unique case (state_ff)
         S_DISPATCH: begin
            cmd.scan_start = (stat.kind == KIND_LOAD);
            cmd.dec_update = (stat.kind == KIND_REV);
            cmd.fwd_prep   = (stat.kind == KIND_FWD);
         end
         S_DEC:  cmd.scan_start = stat.dec_complete;
         S_SCAN: cmd.scan_step  = 1'b1;
         S_LOAD: cmd.load_commit = rsp_free && stat.kind == KIND_LOAD;
         S_EMIT: begin
            cmd.shift_out  = rsp_free && stat.kind == KIND_FWD;
            cmd.rev_result = rsp_free && stat.kind == KIND_REV;
         end
         default: ;
      endcase
      // hold a stalled result, raise valid whenever a new one is registered
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.load_commit || cmd.shift_out || cmd.rev_result) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE:     if (take) state_ff <= S_DISPATCH;
            S_DISPATCH: begin
               unique case (stat.kind)
                  KIND_LOAD: state_ff <= S_SCAN;
                  KIND_REV:  state_ff <= S_DEC;
                  default:   state_ff <= S_FWD;
               endcase
            end
            S_DEC:  state_ff <= stat.dec_complete ? S_SCAN : S_IDLE;
            S_SCAN: if (stat.scan_done && !cmd.scan_start)
                       state_ff <= (stat.kind == KIND_LOAD) ? S_LOAD : S_EMIT;
            S_LOAD: if (rsp_free) state_ff <= S_IDLE;
            S_FWD:  state_ff <= S_EMIT;
            S_EMIT: if (rsp_free && (stat.kind != KIND_FWD || stat.nbytes == 3'd1))
                       state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- hw/rtl/codepage_utf8_transcoder_top.sv -----
// ----------------------------------------------------------------------------
// codepage_utf8_transcoder_top: codepage <-> UTF-8 transcoder
// Forward items: the forward table is read on capture, the UTF-8 bytes are built,
// then one byte a cycle while the output does not stall. Load and completing
// reverse items scan the reverse table entries loaded so far before their result.
// Throughput: one item in flight; input stalls until its last result is held.
// Reset clears fallbacks to 63, forward valid bits, table fill and decoder.
// ----------------------------------------------------------------------------
module codepage_utf8_transcoder_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  cputf8_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output cputf8_pkg::rsp_type rsp_data,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [20:0]         csr_wdata
);
   import cputf8_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // sequencing: handshake and step order
   cputf8_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_kind(req_data.kind),
      .rsp_valid, .rsp_stall, .stat, .cmd
   );

   // tables, scan, encode and decode
   cputf8_datapath u_dp (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .item(req_data), .cmd, .stat, .result(rsp_data)
   );

endmodule
